### src/ade_pkg.sv
`default_nettype none

package ade_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_QUERY      = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]                func;
        logic signed [VALUE_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] removed_value;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } result_t;

endpackage

`default_nettype wire

### src/ade_ram.sv
`default_nettype none

module ade_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/array_deque_engine_unit.sv
`default_nettype none

// Double-ended queue kept in a linear (non-circular) array of DEPTH entries.
// Command beat: cmd is taken at a rising edge where start is high and busy
// is low. Every command produces exactly one result beat: result is valid
// for the single cycle in which done is high, and the receiver cannot stall.
// A command accepted at edge N has its result on the ports in the cycle
// after N, and busy is high for that cycle, so the engine cannot take a
// new command until that result is out. The wait is set by the registered
// read of the element RAM: a pop fetches the new front or back entry, and
// the result waits for that read. Front and back values are cached in
// registers, so each command needs at most one RAM read and one RAM write.
// Push into a full end returns overflow and changes nothing; a pop on an
// empty deque returns underflow. Removing the last element resets both
// indices so the next push lands at index 0.
// Reset (rst_n low, asynchronous) empties the deque and leaves the engine
// idle; the RAM contents are not cleared and need no clearing pass, since
// only entries written by a push are ever read.
module array_deque_engine_unit
    import ade_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t cmd,
    output logic      busy,
    output logic      done,
    output result_t   result
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = IDXW + 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [IDXW-1:0] head_reg, head_next;
    logic [IDXW-1:0] tail_reg, tail_next;
    logic            occ_reg, occ_next;
    logic            rd_front_reg, rd_front_next;
    logic            rd_back_reg, rd_back_next;

    logic signed [VALUE_W-1:0] front_reg, front_next;
    logic signed [VALUE_W-1:0] back_reg, back_next;
    logic signed [VALUE_W-1:0] removed_reg, removed_next;
    logic [1:0]                status_reg, status_next;

    logic                accept;
    logic                ram_we;
    logic [IDXW-1:0]     ram_waddr;
    logic [IDXW-1:0]     ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;
    logic [CW-1:0]       cnt;

    assign accept = start && (state_reg == S_IDLE);

    // A pop from the back fetches the entry below the tail; anything else
    // fetches the entry above the head, which only matters for a pop from the front.
    assign ram_raddr = (cmd.func == FUNC_POP_BACK) ? (tail_reg - 1'b1) : (head_reg + 1'b1);

    ade_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH),
        .AW   (IDXW)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(cmd.push_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        rd_front_next = rd_front_reg;
        rd_back_next  = rd_back_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_FINISH;
                    rd_front_next = 1'b0;
                    rd_back_next  = 1'b0;
                    removed_next  = '0;
                    status_next   = ST_OK;
                    unique case (cmd.func)
                        FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                        begin
                            if (!occ_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                occ_next   = 1'b1;
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                front_next = cmd.push_value;
                                back_next  = cmd.push_value;
                            end
                            else if (cmd.func == FUNC_PUSH_FRONT)
                            begin
                                if (head_reg == '0)
                                begin
                                    status_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    head_next  = head_reg - 1'b1;
                                    ram_we     = 1'b1;
                                    ram_waddr  = head_reg - 1'b1;
                                    front_next = cmd.push_value;
                                end
                            end
                            else
                            begin
                                if (tail_reg >= LAST_IDX)
                                begin
                                    status_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    tail_next = tail_reg + 1'b1;
                                    ram_we    = 1'b1;
                                    ram_waddr = tail_reg + 1'b1;
                                    back_next = cmd.push_value;
                                end
                            end
                        end
                        FUNC_POP_FRONT, FUNC_POP_BACK:
                        begin
                            if (!occ_reg)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else if (head_reg == tail_reg)
                            begin
                                removed_next = (cmd.func == FUNC_POP_FRONT) ? front_reg
                                                                            : back_reg;
                                head_next    = '0;
                                tail_next    = '0;
                                occ_next     = 1'b0;
                            end
                            else if (cmd.func == FUNC_POP_FRONT)
                            begin
                                removed_next  = front_reg;
                                head_next     = head_reg + 1'b1;
                                rd_front_next = 1'b1;
                            end
                            else
                            begin
                                removed_next = back_reg;
                                tail_next    = tail_reg - 1'b1;
                                rd_back_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Query and unused codes leave the deque as it is.
                        end
                    endcase
                end
            end
            S_FINISH:
            begin
                state_next    = S_IDLE;
                rd_front_next = 1'b0;
                rd_back_next  = 1'b0;
                if (rd_front_reg)
                begin
                    front_next = ram_rdata;
                end
                if (rd_back_reg)
                begin
                    back_next = ram_rdata;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= 1'b0;
            rd_front_reg <= 1'b0;
            rd_back_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            rd_front_reg <= rd_front_next;
            rd_back_reg  <= rd_back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg   <= front_next;
        back_reg    <= back_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign cnt = occ_reg ? (CW'(tail_reg) - CW'(head_reg) + CW'(1)) : '0;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FINISH);

    always_comb
    begin
        result.status        = status_reg;
        result.removed_value = removed_reg;
        result.count         = COUNT_W'(cnt);
        result.is_empty      = !occ_reg;
        if (!occ_reg)
        begin
            result.front_value = EMPTY_VALUE;
            result.back_value  = EMPTY_VALUE;
        end
        else
        begin
            // The fresh RAM word stands in for the cache in the cycle it arrives.
            result.front_value = rd_front_reg ? ram_rdata : front_reg;
            result.back_value  = rd_back_reg ? ram_rdata : back_reg;
        end
    end

endmodule

`default_nettype wire
